@@ hdl/bfp_pkg.sv @@
//------------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants for the BEEP frame parser.
//------------------------------------------------------------------------------
package bfp_pkg;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_DONE = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	localparam logic [2:0] TYPE_MSG = 3'd0;
	localparam logic [2:0] TYPE_RPY = 3'd1;
	localparam logic [2:0] TYPE_ANS = 3'd2;
	localparam logic [2:0] TYPE_ERR = 3'd3;
	localparam logic [2:0] TYPE_NUL = 3'd4;
	localparam logic [2:0] TYPE_SEQ = 3'd5;
	localparam logic [2:0] TYPE_NONE = 3'd6;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  frame_type;
		logic [30:0] channel;
		logic [30:0] msg_num;
		logic        more;
		logic [31:0] seq_num;
		logic [30:0] payload_size;
		logic [31:0] ans_num;
		logic [7:0]  payload_byte;
		logic        last_payload;
	} result_t;

	// keyword letter by type and position
	function automatic logic [7:0] kw_char(input logic [2:0] t, input logic [1:0] p);
		logic [23:0] w;
		case (t)
			TYPE_MSG: w = "MSG";
			TYPE_RPY: w = "RPY";
			TYPE_ANS: w = "ANS";
			TYPE_ERR: w = "ERR";
			TYPE_NUL: w = "NUL";
			TYPE_SEQ: w = "SEQ";
			default: w = 24'd0;
		endcase
		case (p)
			2'd0: kw_char = w[23:16];
			2'd1: kw_char = w[15:8];
			2'd2: kw_char = w[7:0];
			default: kw_char = 8'd0;
		endcase
	endfunction

	function automatic logic [2:0] start_type(input logic [7:0] b);
		case (b)
			"M": start_type = TYPE_MSG;
			"R": start_type = TYPE_RPY;
			"A": start_type = TYPE_ANS;
			"E": start_type = TYPE_ERR;
			"N": start_type = TYPE_NUL;
			"S": start_type = TYPE_SEQ;
			default: start_type = TYPE_NONE;
		endcase
	endfunction

endpackage

@@ hdl/bfp_core.sv @@
//------------------------------------------------------------------------------
// bfp_core
// Per-byte state transition, decimal accumulate and result forming.
//------------------------------------------------------------------------------
module bfp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        b,
	input  logic              seq_en,
	output logic              res_valid,
	output bfp_pkg::result_t  res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_RECOVER, PH_KEYWORD, PH_CHANNEL, PH_MSGNO, PH_MORE, PH_SEQNO,
		PH_SIZE, PH_ANSNO, PH_CR, PH_LF, PH_PAYLOAD, PH_TRAIL, PH_TCR, PH_TLF
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [1:0]  kp_q, kp_n;
	logic [2:0]  type_q, type_n;
	logic [31:0] acc_q, acc_n;
	logic        seen_q, seen_n;
	logic [30:0] ch_q, ch_n, msg_q, msg_n, size_q, size_n, rem_q, rem_n;
	logic        more_q, more_n;
	logic [31:0] seqn_q, seqn_n, ans_q, ans_n;

	logic        blank, digit, big;
	logic [35:0] acc10;
	logic [2:0]  st;
	phase_t      numph;
	logic [30:0] rem_dec;

	assign blank = (b == 8'h20) || (b == 8'h09);
	assign digit = (b >= "0") && (b <= "9");
	assign acc10 = {4'd0, acc_q} * 36'd10 + {32'd0, b[3:0]};
	assign st = bfp_pkg::start_type(b);
	assign rem_dec = (rem_q != 31'd0) ? rem_q - 31'd1 : rem_q;

	always_comb begin
		res_valid = 1'b0;
		res = '0;
		phase_n = phase_q; kp_n = kp_q; type_n = type_q; acc_n = acc_q;
		seen_n = seen_q; ch_n = ch_q; msg_n = msg_q; more_n = more_q;
		seqn_n = seqn_q; size_n = size_q; ans_n = ans_q; rem_n = rem_q;
		big = 1'b0;
		numph = phase_q;
		case (phase_q)
			PH_IDLE, PH_RECOVER: begin
				if (!blank) begin
					if (st != bfp_pkg::TYPE_NONE && (st != bfp_pkg::TYPE_SEQ || seq_en)) begin
						type_n = st; kp_n = 2'd1; acc_n = '0; seen_n = 1'b0;
						ch_n = '0; msg_n = '0; more_n = 1'b0; seqn_n = '0;
						size_n = '0; ans_n = '0; rem_n = '0;
						phase_n = PH_KEYWORD;
					end else if (phase_q == PH_IDLE) begin
						res_valid = 1'b1;
					end
				end
			end
			PH_KEYWORD: begin
				if (b != bfp_pkg::kw_char(type_q, kp_q) || kp_q == 2'd3) res_valid = 1'b1;
				else if (kp_q == 2'd2) begin
					kp_n = 2'd0; phase_n = PH_CHANNEL;
				end else kp_n = kp_q + 2'd1;
			end
			PH_CHANNEL, PH_MSGNO, PH_SEQNO, PH_SIZE, PH_ANSNO: begin
				big = (phase_q == PH_SEQNO || phase_q == PH_ANSNO) ? (acc10[35:32] != 4'd0)
					: (acc10[35:31] != 5'd0);
				if (digit) begin
					if (big) res_valid = 1'b1;
					else begin
						acc_n = acc10[31:0]; seen_n = 1'b1;
					end
				end else if (!seen_q) begin
					if (!blank) res_valid = 1'b1;
				end else begin
					acc_n = '0; seen_n = 1'b0;
					case (phase_q)
						PH_CHANNEL: begin
							ch_n = acc_q[30:0];
							numph = (type_q == bfp_pkg::TYPE_SEQ) ? PH_SEQNO : PH_MORE;
						end
						PH_MSGNO: begin msg_n = acc_q[30:0]; numph = PH_MORE; end
						PH_SEQNO: begin seqn_n = acc_q; numph = PH_SIZE; end
						PH_SIZE: begin
							size_n = acc_q[30:0];
							numph = (type_q == bfp_pkg::TYPE_ANS) ? PH_ANSNO : PH_CR;
						end
						default: begin ans_n = acc_q; numph = PH_CR; end
					endcase
					// terminating octet goes to the next phase right away
					if (phase_q == PH_CHANNEL && type_q != bfp_pkg::TYPE_SEQ) begin
						phase_n = PH_MSGNO;
						// MSGNO with no digits yet
						if (!blank) res_valid = 1'b1;
					end else if (numph == PH_MORE) begin
						phase_n = PH_MORE;
						if (!blank) begin
							if (b == "*") begin more_n = 1'b1; phase_n = PH_SEQNO; end
							else if (b == ".") begin more_n = 1'b0; phase_n = PH_SEQNO; end
							else res_valid = 1'b1;
						end
					end else if (numph == PH_CR) begin
						phase_n = PH_CR;
						if (!blank) begin
							if (b == 8'h0D) phase_n = PH_LF;
							else res_valid = 1'b1;
						end
					end else begin
						// next phase is a number and current octet is a non-digit
						phase_n = numph;
						if (!blank) res_valid = 1'b1;
					end
				end
			end
			PH_MORE: begin
				if (!blank) begin
					if (b == "*") begin more_n = 1'b1; phase_n = PH_SEQNO; end
					else if (b == ".") begin more_n = 1'b0; phase_n = PH_SEQNO; end
					else res_valid = 1'b1;
				end
			end
			PH_CR: begin
				if (!blank) begin
					if (b == 8'h0D) phase_n = PH_LF;
					else res_valid = 1'b1;
				end
			end
			PH_LF: begin
				if (b != 8'h0A) res_valid = 1'b1;
				else begin
					res_valid = 1'b1;
					if (type_q == bfp_pkg::TYPE_SEQ) begin
						phase_n = PH_IDLE;
						res.kind = bfp_pkg::KIND_DONE;
					end else begin
						rem_n = size_q; kp_n = 2'd0;
						phase_n = (size_q != 31'd0) ? PH_PAYLOAD : PH_TRAIL;
						res.kind = bfp_pkg::KIND_HEADER;
					end
				end
			end
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				res.kind = bfp_pkg::KIND_PAYLOAD;
				res.payload_byte = b;
				rem_n = rem_dec;
				if (rem_dec == 31'd0) begin
					kp_n = 2'd0; phase_n = PH_TRAIL; res.last_payload = 1'b1;
				end
			end
			PH_TRAIL: begin
				// trailer keyword END, blanks only before its first letter
				if (!(kp_q == 2'd0 && blank)) begin
					if (kp_q == 2'd3
						|| (kp_q == 2'd0 && b != "E")
						|| (kp_q == 2'd1 && b != "N")
						|| (kp_q == 2'd2 && b != "D")) res_valid = 1'b1;
					else if (kp_q == 2'd2) begin kp_n = 2'd0; phase_n = PH_TCR; end
					else kp_n = kp_q + 2'd1;
				end
			end
			PH_TCR: begin
				if (b == 8'h0D) phase_n = PH_TLF;
				else res_valid = 1'b1;
			end
			PH_TLF: begin
				res_valid = 1'b1;
				if (b == 8'h0A) begin
					phase_n = PH_IDLE; res.kind = bfp_pkg::KIND_DONE;
				end
			end
			default: res_valid = 1'b1;
		endcase
		if (res_valid && res.kind == bfp_pkg::KIND_HEADER && !(phase_q == PH_LF && b == 8'h0A))
			res.kind = bfp_pkg::KIND_ERROR;
		if (res_valid && res.kind == bfp_pkg::KIND_DONE && !((phase_q == PH_LF || phase_q == PH_TLF)
			&& b == 8'h0A)) res.kind = bfp_pkg::KIND_ERROR;
		if (res_valid && res.kind == bfp_pkg::KIND_ERROR) begin
			phase_n = PH_RECOVER; kp_n = 2'd0; acc_n = '0; seen_n = 1'b0;
			res = '0;
			res.kind = bfp_pkg::KIND_ERROR;
		end else if (res_valid) begin
			res.frame_type = type_q;
			res.channel = ch_q;
			res.msg_num = msg_q;
			res.more = more_q;
			res.seq_num = seqn_q;
			res.payload_size = size_q;
			res.ans_num = ans_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; kp_q <= '0; type_q <= '0; acc_q <= '0; seen_q <= 1'b0;
			ch_q <= '0; msg_q <= '0; more_q <= 1'b0; seqn_q <= '0; size_q <= '0;
			ans_q <= '0; rem_q <= '0;
		end else if (step) begin
			phase_q <= phase_n; kp_q <= kp_n; type_q <= type_n; acc_q <= acc_n;
			seen_q <= seen_n; ch_q <= ch_n; msg_q <= msg_n; more_q <= more_n;
			seqn_q <= seqn_n; size_q <= size_n; ans_q <= ans_n; rem_q <= rem_n;
		end
	end

	a_kw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEYWORD) |-> (kp_q != 2'd0 && kp_q != 2'd3))
		else $error("keyword progress out of range");
	a_pay_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (rem_q != 31'd0))
		else $error("payload phase with nothing left");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == bfp_pkg::KIND_ERROR) |-> (res.channel == 31'd0))
		else $error("error result carries fields");

endmodule

@@ hdl/beep_frame_parser_top.sv @@
//------------------------------------------------------------------------------
// beep_frame_parser_top
// Byte-serial BEEP frame parser with registered result stage.
//------------------------------------------------------------------------------
// A byte's result, if any, is registered at the same edge that accepts the byte.
// Throughput: one byte per cycle when not blocked; the parse state updates once per beat.
// A held result blocks input only when the result register is full and out_ready is low.
// Reset (arst_n low) clears the parse state to waiting for keyword and sets seq_enable.
module beep_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [2:0]  frame_type,
	output logic [30:0] channel,
	output logic [30:0] msg_num,
	output logic        more,
	output logic [31:0] seq_num,
	output logic [30:0] payload_size,
	output logic [31:0] ans_num,
	output logic [7:0]  payload_byte,
	output logic        last_payload
);

	logic             seq_en_q, step, rv;
	bfp_pkg::result_t r, res_q;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid || out_ready;
	assign step = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seq_en_q <= 1'b1;
		else if (cfg_valid) seq_en_q <= cfg_data;
	end

	bfp_core u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .b(byte_value),
		.seq_en(seq_en_q), .res_valid(rv), .res(r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (in_ready) out_valid <= step && rv;
	end

	always_ff @(posedge clk) begin
		if (step && rv) res_q <= r;
	end

	assign kind = res_q.kind;
	assign frame_type = res_q.frame_type;
	assign channel = res_q.channel;
	assign msg_num = res_q.msg_num;
	assign more = res_q.more;
	assign seq_num = res_q.seq_num;
	assign payload_size = res_q.payload_size;
	assign ans_num = res_q.ans_num;
	assign payload_byte = res_q.payload_byte;
	assign last_payload = res_q.last_payload;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(res_q)))
		else $error("result dropped while stalled");
	a_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !step)
		else $error("byte taken while result stalled");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		(step && rv) |=> out_valid)
		else $error("result not registered");

endmodule
